/* src/assert_macros.svh */
// assertion macros used by the sender rtl
// no dependencies; assertions vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SR_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define SR_ASSERT(lbl, clk, rst_n, prop)
`define SR_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`endif
`endif

/* src/srs_pkg.sv */
// constants, types and helpers of the selective-repeat sender
// no dependencies
package srs_pkg;
  localparam int SEQ_SPACE     = 12;
  localparam int WINDOW        = 6;
  localparam int PAYLOAD_BYTES = 20;
  localparam int MAX_RESULTS   = 6;
  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int WIN_IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int PL_W    = 160;
  localparam int SUM_W   = 13;
  localparam int GRP     = 4;
  localparam int GRP_B   = 5;

  typedef enum logic [1:0] {
    CMD_NEW = 2'd0, CMD_ACK = 2'd1, CMD_TIMEOUT = 2'd2, CMD_NONE = 2'd3
  } cmd_t;
  typedef enum logic [1:0] {
    KIND_SENT = 2'd0, KIND_DROP = 2'd1, KIND_ACK = 2'd2, KIND_RSVD = 2'd3
  } kind_t;
  typedef enum logic [3:0] {
    ST_IDLE, ST_PART, ST_SUM, ST_NEW, ST_ACK, ST_SLIDE, ST_OUTS,
    ST_TO_SCAN, ST_TO_RD, ST_TO_EMIT
  } state_t;

  function automatic logic [PL_W-1:0] keep_mask();
    logic [PL_W-1:0] m;
    m = '0;
    for (int k = 0; k < PL_W / 8; k++) begin
      if (k < PAYLOAD_BYTES) m[k*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction
  localparam logic [PL_W-1:0] KEEP_MASK = keep_mask();

  // (a + b) mod SEQ_SPACE for a < SEQ_SPACE, b < SEQ_SPACE
  function automatic logic [SEQ_W-1:0] wrap_add(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SEQ_W+1)'(SEQ_SPACE)) s = s - (SEQ_W+1)'(SEQ_SPACE);
    return s[SEQ_W-1:0];
  endfunction

  // (a - b) mod SEQ_SPACE
  function automatic logic [SEQ_W-1:0] wrap_sub(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, b};
    return s[SEQ_W-1:0];
  endfunction
endpackage

/* src/selective_repeat_sender.sv */
// selective-repeat arq sender, single module with slot memory and flag vectors
// depends on srs_pkg and assert_macros.svh
//
// usage
//   input stream: in_tuser carries the command (new message, ack arrives,
//   retransmit timeout), in_tdata the ack fields and the 20 payload bytes.
//   result stream: out_tuser carries the result kind, out_tdata the packet,
//   the timer controls and the new-ack flag, out_tlast the final result of
//   the command.
// sequencing
//   one command is worked at a time; in_tready is high only when idle.
//   each command is registered and its payload bytes summed first; a new
//   message then gives its result; a valid ack slides the base past up to 6
//   acknowledged slots; a timeout resends each outstanding packet after a
//   registered read of the slot memory; a command with no result frees the block.
// reset
//   rst_n low clears window base, next sequence and the sent/acked flags;
//   slot memory contents are undefined until written, no clearing pass.
// back pressure
//   results sit in an output register; while one waits and out_tready is low
//   the block holds in its emit state, and a new command is taken once it is idle.
module selective_repeat_sender (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pkt_seq, pkt_ack, payload_lo, payload_mid, payload_hi, pkt_sum
  input  logic [255:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_seq, out_ack, out_payload_lo, out_payload_mid, out_payload_hi,
  // out_sum, timer_start, timer_stop, new_ack, zero pad
  output logic [183:0] out_tdata,
  // kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import srs_pkg::*;

  localparam int MEM_W = PL_W + SUM_W;

  // slot memory: payload and checksum, registered read
  logic [MEM_W-1:0] mem [SEQ_SPACE];
  logic             mem_we;
  logic [SEQ_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [SEQ_W-1:0] mem_raddr;
  logic [MEM_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end
  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  state_t state_r, state_nxt;

  // control state
  logic [SEQ_SPACE-1:0] sent_r, sent_nxt;
  logic [SEQ_SPACE-1:0] acked_r, acked_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // command payload
  cmd_t                 cmd_r, cmd_nxt;
  logic [31:0]          seq_r, seq_nxt;
  logic [31:0]          ack_r, ack_nxt;
  logic [31:0]          psum_r, psum_nxt;
  logic [PL_W-1:0]      pl_r, pl_nxt;
  logic signed [SUM_W-1:0] part_r [GRP];
  logic signed [SUM_W-1:0] part_nxt [GRP];
  logic signed [SUM_W-1:0] bsum_r, bsum_nxt;
  logic                 newack_r, newack_nxt;
  logic [WINDOW-1:0]    tmask_r, tmask_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]     rseq_r, rseq_nxt;

  // output register
  kind_t                o_kind_r, o_kind_nxt;
  logic [SEQ_W-1:0]     o_seq_r, o_seq_nxt;
  logic [PL_W-1:0]      o_pl_r, o_pl_nxt;
  logic [SUM_W-1:0]     o_sum_r, o_sum_nxt;
  logic                 o_start_r, o_start_nxt;
  logic                 o_stop_r, o_stop_nxt;
  logic                 o_new_r, o_new_nxt;
  logic                 o_last_r, o_last_nxt;

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // window helpers
  logic [SEQ_W-1:0]  used;
  logic [WINDOW-1:0] outstanding;
  logic [SEQ_W-1:0]  ack_off;
  logic [31:0]       calc;
  logic [WIN_IW-1:0] first_pos;
  logic              any_out;

  always_comb begin
    logic [SEQ_W-1:0] idx;
    used = wrap_sub(next_r, base_r);
    for (int i = 0; i < WINDOW; i++) begin
      idx = wrap_add(base_r, SEQ_W'(i));
      outstanding[i] = sent_r[idx] && !acked_r[idx];
    end
    any_out = |outstanding;
    ack_off = wrap_sub(ack_r[SEQ_W-1:0], base_r);
    calc = seq_r + ack_r + 32'(bsum_r);
    first_pos = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (tmask_r[i]) first_pos = WIN_IW'(i);
    end
  end

  always_comb begin
    logic [SEQ_W-1:0] a;
    state_nxt = state_r;
    sent_nxt = sent_r;
    acked_nxt = acked_r;
    base_nxt = base_r;
    next_nxt = next_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd_nxt = cmd_r;
    seq_nxt = seq_r;
    ack_nxt = ack_r;
    psum_nxt = psum_r;
    pl_nxt = pl_r;
    part_nxt = part_r;
    bsum_nxt = bsum_r;
    newack_nxt = newack_r;
    tmask_nxt = tmask_r;
    cnt_nxt = cnt_r;
    rseq_nxt = rseq_r;
    o_kind_nxt = o_kind_r;
    o_seq_nxt = o_seq_r;
    o_pl_nxt = o_pl_r;
    o_sum_nxt = o_sum_r;
    o_start_nxt = o_start_r;
    o_stop_nxt = o_stop_r;
    o_new_nxt = o_new_r;
    o_last_nxt = o_last_r;
    mem_we = 1'b0;
    mem_waddr = next_r;
    mem_wdata = {bsum_r + SUM_W'(next_r) - SUM_W'(1), pl_r};
    mem_re = 1'b0;
    mem_raddr = wrap_add(base_r, SEQ_W'(first_pos));
    a = ack_r[SEQ_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = cmd_t'(in_tuser);
          seq_nxt = in_tdata[31:0];
          ack_nxt = in_tdata[63:32];
          pl_nxt = in_tdata[223:64] & KEEP_MASK;
          psum_nxt = in_tdata[255:224];
          state_nxt = ST_PART;
        end
      end
      ST_PART: begin
        // four groups of five signed bytes
        for (int g = 0; g < GRP; g++) begin
          part_nxt[g] = '0;
          for (int k = 0; k < GRP_B; k++) begin
            part_nxt[g] = part_nxt[g]
              + SUM_W'(signed'(pl_r[(g*GRP_B + k)*8 +: 8]));
          end
        end
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        bsum_nxt = part_r[0] + part_r[1] + part_r[2] + part_r[3];
        case (cmd_r)
          CMD_NEW:     state_nxt = ST_NEW;
          CMD_ACK:     state_nxt = ST_ACK;
          CMD_TIMEOUT: state_nxt = ST_TO_SCAN;
          default:     state_nxt = ST_IDLE;
        endcase
      end
      ST_NEW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_stop_nxt = 1'b0;
          o_new_nxt = 1'b0;
          o_last_nxt = 1'b1;
          if (used < SEQ_W'(WINDOW)) begin
            mem_we = 1'b1;
            sent_nxt[next_r] = 1'b1;
            acked_nxt[next_r] = 1'b0;
            next_nxt = wrap_add(next_r, SEQ_W'(1));
            o_kind_nxt = KIND_SENT;
            o_seq_nxt = next_r;
            o_pl_nxt = pl_r;
            o_sum_nxt = mem_wdata[MEM_W-1:PL_W];
            o_start_nxt = (base_r == next_r);
          end else begin
            o_kind_nxt = KIND_DROP;
            o_seq_nxt = '0;
            o_pl_nxt = '0;
            o_sum_nxt = '0;
            o_start_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_ACK: begin
        newack_nxt = 1'b0;
        if (calc != psum_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt = KIND_ACK;
            o_seq_nxt = '0;
            o_pl_nxt = '0;
            o_sum_nxt = '0;
            o_start_nxt = 1'b0;
            o_stop_nxt = 1'b0;
            o_new_nxt = 1'b0;
            o_last_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (ack_r < 32'(SEQ_SPACE) && sent_r[a] && !acked_r[a]
              && ack_off < SEQ_W'(WINDOW)) begin
            acked_nxt[a] = 1'b1;
            newack_nxt = 1'b1;
          end
          state_nxt = ST_SLIDE;
        end
      end
      ST_SLIDE: begin
        // one slot per cycle past acknowledged slots
        if (acked_r[base_r]) begin
          sent_nxt[base_r] = 1'b0;
          acked_nxt[base_r] = 1'b0;
          base_nxt = wrap_add(base_r, SEQ_W'(1));
        end else begin
          state_nxt = ST_OUTS;
        end
      end
      ST_OUTS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt = KIND_ACK;
          o_seq_nxt = '0;
          o_pl_nxt = '0;
          o_sum_nxt = '0;
          o_start_nxt = any_out;
          o_stop_nxt = 1'b1;
          o_new_nxt = newack_r;
          o_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TO_SCAN: begin
        tmask_nxt = outstanding;
        cnt_nxt = '0;
        state_nxt = any_out ? ST_TO_RD : ST_IDLE;
      end
      ST_TO_RD: begin
        mem_re = 1'b1;
        rseq_nxt = mem_raddr;
        tmask_nxt[first_pos] = 1'b0;
        state_nxt = ST_TO_EMIT;
      end
      ST_TO_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt = KIND_SENT;
          o_seq_nxt = rseq_r;
          o_pl_nxt = mem_rdata_r[PL_W-1:0];
          o_sum_nxt = mem_rdata_r[MEM_W-1:PL_W];
          o_start_nxt = (cnt_r == '0);
          o_stop_nxt = 1'b0;
          o_new_nxt = 1'b0;
          o_last_nxt = (tmask_r == '0) || (cnt_r == CNT_W'(MAX_RESULTS - 1));
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = o_last_nxt ? ST_IDLE : ST_TO_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= '0;
      acked_r <= '0;
      base_r <= '0;
      next_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      acked_r <= acked_nxt;
      base_r <= base_nxt;
      next_r <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    seq_r <= seq_nxt;
    ack_r <= ack_nxt;
    psum_r <= psum_nxt;
    pl_r <= pl_nxt;
    part_r <= part_nxt;
    bsum_r <= bsum_nxt;
    newack_r <= newack_nxt;
    tmask_r <= tmask_nxt;
    cnt_r <= cnt_nxt;
    rseq_r <= rseq_nxt;
    o_kind_r <= o_kind_nxt;
    o_seq_r <= o_seq_nxt;
    o_pl_r <= o_pl_nxt;
    o_sum_r <= o_sum_nxt;
    o_start_r <= o_start_nxt;
    o_stop_r <= o_stop_nxt;
    o_new_r <= o_new_nxt;
    o_last_r <= o_last_nxt;
  end

  // out_ack is always -1
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_new_r, o_stop_r, o_start_r, o_sum_r, o_pl_r,
                       2'b11, o_seq_r};

  `include "assert_macros.svh"
  `SR_ASSERT(a_window_fill, clk, rst_n, used <= SEQ_W'(WINDOW))
  `SR_ASSERT(a_acked_sent, clk, rst_n, (acked_r & ~sent_r) == '0)
  `SR_ASSERT_IMP(a_base_slid, clk, rst_n, state_r == ST_IDLE, !acked_r[base_r])
  `SR_ASSERT(a_ptr_range, clk, rst_n,
    base_r < SEQ_W'(SEQ_SPACE) && next_r < SEQ_W'(SEQ_SPACE))
endmodule

/* tb/selective_repeat_sender_checker.sv */
// checker for the selective-repeat sender: watches both streams, predicts results
// depends on srs_pkg for the window constants and the command and kind codes
`timescale 1ns / 100ps

module selective_repeat_sender_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [183:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           errors,
  output int           pending,
  output int           results
);
  import srs_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  seq;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
    logic [12:0] sum;
    logic        start;
    logic        stop;
    logic        newack;
    logic        last;
  } pkt_result_t;

  pkt_result_t result_q[$];

  logic [63:0] mem_lo[SEQ_SPACE];
  logic [63:0] mem_mid[SEQ_SPACE];
  logic [31:0] mem_hi[SEQ_SPACE];
  logic [12:0] mem_sum[SEQ_SPACE];
  logic        sent_f[SEQ_SPACE];
  logic        acked_f[SEQ_SPACE];
  int          base_p;
  int          next_p;

  assign pending = result_q.size();

  function automatic logic [31:0] payload_sum(logic [159:0] pl);
    logic [31:0] s;
    s = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) s += 32'(signed'(pl[k*8 +: 8]));
    return s;
  endfunction

  function automatic pkt_result_t slot_result(kind_t kind, int slot, logic start);
    pkt_result_t r;
    r = '0;
    r.kind = kind;
    r.start = start;
    if (slot >= 0) begin
      r.seq = 4'(slot);
      r.lo = mem_lo[slot];
      r.mid = mem_mid[slot];
      r.hi = mem_hi[slot];
      r.sum = mem_sum[slot];
    end
    return r;
  endfunction

  // advance the sender model by one command and queue what it emits
  task automatic step_window(logic [1:0] cmd, logic [255:0] d);
    logic [31:0]  seqv, ackv, sumv;
    logic [159:0] pl;
    pkt_result_t  r;
    int           b, e, idx, n;
    logic         inw, outs;
    seqv = d[31:0];
    ackv = d[63:32];
    pl = d[223:64];
    sumv = d[255:224];
    n = 0;
    case (cmd)
      CMD_NEW: begin
        if ((next_p + SEQ_SPACE - base_p) % SEQ_SPACE < WINDOW) begin
          mem_lo[next_p] = pl[63:0];
          mem_mid[next_p] = pl[127:64];
          mem_hi[next_p] = pl[159:128];
          mem_sum[next_p] = 13'(32'(next_p) - 32'd1 + payload_sum(pl));
          sent_f[next_p] = 1'b1;
          acked_f[next_p] = 1'b0;
          r = slot_result(KIND_SENT, next_p, base_p == next_p);
          next_p = (next_p + 1) % SEQ_SPACE;
        end else begin
          r = slot_result(KIND_DROP, -1, 1'b0);
        end
        r.last = 1'b1;
        result_q.push_back(r);
      end
      CMD_ACK: begin
        r = slot_result(KIND_ACK, -1, 1'b0);
        if (seqv + ackv + payload_sum(pl) == sumv) begin
          b = base_p;
          e = (b + WINDOW) % SEQ_SPACE;
          if (ackv < SEQ_SPACE) begin
            inw = (b <= e) ? (ackv >= b && ackv < e) : (ackv >= b || ackv < e);
            if (sent_f[ackv] && !acked_f[ackv] && inw) begin
              acked_f[ackv] = 1'b1;
              r.newack = 1'b1;
            end
          end
          for (int i = 0; i < SEQ_SPACE && acked_f[b]; i++) begin
            sent_f[b] = 1'b0;
            acked_f[b] = 1'b0;
            b = (b + 1) % SEQ_SPACE;
          end
          base_p = b;
          outs = 1'b0;
          for (int i = 0; i < WINDOW; i++) begin
            idx = (b + i) % SEQ_SPACE;
            if (sent_f[idx] && !acked_f[idx]) outs = 1'b1;
          end
          r.start = outs;
          r.stop = 1'b1;
        end
        r.last = 1'b1;
        result_q.push_back(r);
      end
      CMD_TIMEOUT: begin
        for (int i = 0; i < WINDOW && n < MAX_RESULTS; i++) begin
          idx = (base_p + i) % SEQ_SPACE;
          if (sent_f[idx] && !acked_f[idx]) begin
            r = slot_result(KIND_SENT, idx, n == 0);
            result_q.push_back(r);
            n++;
          end
        end
        if (n > 0) result_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", results, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    results = 0;
    base_p = 0;
    next_p = 0;
    for (int i = 0; i < SEQ_SPACE; i++) begin
      sent_f[i] = 1'b0;
      acked_f[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    pkt_result_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) step_window(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("unexpected result transaction, kind %0d", out_tuser);
          errors++;
        end else begin
          w = result_q.pop_front();
          if (out_tuser != w.kind) report("kind", out_tuser, w.kind);
          if (out_tdata[3:0] != w.seq) report("seq", out_tdata[3:0], w.seq);
          if (out_tdata[5:4] != 2'b11) report("ack", out_tdata[5:4], 2'b11);
          if (out_tdata[69:6] != w.lo) report("payload_lo", out_tdata[69:6], w.lo);
          if (out_tdata[133:70] != w.mid) report("payload_mid", out_tdata[133:70], w.mid);
          if (out_tdata[165:134] != w.hi) report("payload_hi", out_tdata[165:134], w.hi);
          if (out_tdata[178:166] != w.sum) report("sum", out_tdata[178:166], w.sum);
          if (out_tdata[179] != w.start) report("timer_start", out_tdata[179], w.start);
          if (out_tdata[180] != w.stop) report("timer_stop", out_tdata[180], w.stop);
          if (out_tdata[181] != w.newack) report("new_ack", out_tdata[181], w.newack);
          if (out_tlast != w.last) report("last", out_tlast, w.last);
        end
        results++;
      end
    end
  end

endmodule

/* tb/selective_repeat_sender_test.sv */
// top of the selective-repeat sender testbench: clock, reset, stimulus and verdict
// depends on srs_pkg, the sender rtl and selective_repeat_sender_checker
`timescale 1ns / 100ps

module selective_repeat_sender_test;
  import srs_pkg::*;

  localparam int RAND_ITEMS = 170;
  localparam int CALM_FROM  = 145;     // no idling on either side from here on
  localparam int CYCLE_CAP  = 300000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  int errors, pending, results;
  int cycles;
  int cmd_count[4];
  logic calm;

  selective_repeat_sender dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  selective_repeat_sender_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .errors, .pending, .results
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver side: random stall bursts until the calm tail of the run
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready = 1'b1;
      if (!calm) repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  function automatic logic [31:0] byte_total(logic [159:0] pl);
    logic [31:0] s;
    s = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) s += 32'(signed'(pl[k*8 +: 8]));
    return s;
  endfunction

  function automatic logic [159:0] rand_payload();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // one input transaction; called at a falling edge, returns at a falling edge
  task automatic send(cmd_t cmd, logic [31:0] seqv, logic [31:0] ackv,
                      logic [159:0] pl, logic [31:0] sumv);
    logic hit;
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {sumv, pl, ackv, seqv};
    cmd_count[cmd]++;
    hit = 1'b0;
    while (!hit) begin
      #1;
      hit = in_tready;
      @(posedge clk);
      @(negedge clk);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // ack with a checksum that matches unless corrupt is set
  task automatic send_ack(logic [31:0] seqv, logic [31:0] ackv, logic [159:0] pl,
                          logic corrupt);
    logic [31:0] s;
    s = seqv + ackv + byte_total(pl);
    if (corrupt) s ^= 32'(1) << $urandom_range(0, 31);
    send(CMD_ACK, seqv, ackv, pl, s);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    calm = 1'b0;
    cycles = 0;
    for (int i = 0; i < 4; i++) cmd_count[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = CMD_NEW;
    in_tdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // timeout and ack with an empty window
    send(CMD_TIMEOUT, '0, '0, '0, '0);
    send_ack(32'd0, 32'd0, '0, 1'b0);
    // payload extremes: zeros, ones, most negative and most positive bytes
    send(CMD_NEW, '0, '0, '0, '0);
    send(CMD_NEW, '0, '0, '1, '0);
    send(CMD_NEW, '0, '0, {20{8'h80}}, '0);
    send(CMD_NEW, '0, '0, {20{8'h7F}}, '0);
    send(CMD_NEW, '0, '0, rand_payload(), '0);
    send(CMD_NEW, '0, '0, rand_payload(), '0);
    // window full, message dropped
    send(CMD_NEW, '0, '0, rand_payload(), '0);
    // resend all six outstanding packets
    send(CMD_TIMEOUT, '0, '0, '0, '0);
    // corrupted ack, ack numbers outside the sequence space, out of window
    send_ack(32'hFFFF_FFFF, 32'd1, '1, 1'b1);
    send_ack(32'h7FFF_FFFF, 32'd12, rand_payload(), 1'b0);
    send_ack(32'h8000_0000, 32'hFFFF_FFFF, rand_payload(), 1'b0);
    send_ack(32'd5, 32'h7FFF_FFFF, rand_payload(), 1'b0);
    send_ack(32'd0, 32'd8, rand_payload(), 1'b0);
    // out of order ack, then its duplicate, then the base slides
    send_ack(32'd1, 32'd2, rand_payload(), 1'b0);
    send_ack(32'd1, 32'd2, rand_payload(), 1'b0);
    send_ack(32'd0, 32'd0, rand_payload(), 1'b0);
    send_ack(32'd0, 32'd1, rand_payload(), 1'b0);
    send(CMD_NONE, '1, '1, '1, '1);
    send(CMD_TIMEOUT, '0, '0, '0, '0);

    // random traffic: new messages, acks (mostly well-formed, within the sequence space), timeouts, unknown commands
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= CALM_FROM);
      if (n == 90) begin
        in_tvalid = 1'b0;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send(CMD_NEW, $urandom, $urandom, rand_payload(), $urandom);
      else if (pick < 78)
        send_ack($urandom, $urandom_range(0, 11), rand_payload(), 1'b0);
      else if (pick < 82)
        send_ack($urandom, $urandom, rand_payload(), 1'b0);
      else if (pick < 87)
        send_ack($urandom, $urandom_range(0, 11), rand_payload(), 1'b1);
      else if (pick < 97)
        send(CMD_TIMEOUT, $urandom, $urandom, rand_payload(), $urandom);
      else
        send(CMD_NONE, $urandom, $urandom, rand_payload(), $urandom);
    end
    in_tvalid = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d new messages, %0d acks, %0d timeouts, %0d unknown commands",
             cmd_count[CMD_NEW], cmd_count[CMD_ACK], cmd_count[CMD_TIMEOUT],
             cmd_count[CMD_NONE]);
    $display("checked %0d result transactions, %0d mismatches", results, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
